// ----- rtl/ilb_pkg.sv -----
// ilb_pkg: types and constants shared by the indexed line buffer modules.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ilb_pkg;

  // Line storage size and width of lengths and positions
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned CHAR_W   = 8;

  // Request codes as they arrive on the input channel
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_READ     = 3'd2,
    REQ_WRITE    = 3'd3,
    REQ_INS_POP  = 3'd4,
    REQ_POP_HEAD = 3'd5,
    REQ_CLEAR    = 3'd6
  } req_t;

  // What every cell of the chain does under a command
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHR   = 2'd1,  // open a slot at pos, cells up to last move right
    CELL_SHL   = 2'd2,  // close the slot at pos, cells below last move left
    CELL_WRITE = 2'd3   // replace the byte at pos
  } cell_mode_t;

  // Command broadcast to the whole chain
  typedef struct packed {
    cell_mode_t          mode;
    logic [LEN_W-1:0]    pos;
    logic [LEN_W-1:0]    last;
    logic [CHAR_W-1:0]   ch;
  } cell_cmd_t;

endpackage

// ----- rtl/ilb_if.sv -----
// ilb_if: valid/ready channel interfaces for requests and results.
// Depends on ilb_pkg for field widths.
`timescale 1ns / 1ps

interface ilb_req_if;
  logic                        valid;
  logic                        ready;
  logic [ilb_pkg::REQ_W-1:0]   req_type;
  logic [ilb_pkg::LEN_W-1:0]   position;
  logic [ilb_pkg::CHAR_W-1:0]  char_in;

  modport source (output valid, req_type, position, char_in, input ready);
  modport sink   (input valid, req_type, position, char_in, output ready);
endinterface

interface ilb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ilb_pkg::CHAR_W-1:0]  char_out;
  logic [ilb_pkg::LEN_W-1:0]   line_length;
  logic                        error;

  modport source (output valid, char_out, line_length, error, input ready);
  modport sink   (input valid, char_out, line_length, error, output ready);
endinterface

// ----- rtl/ilb_cell.sv -----
// ilb_cell: one byte slot of the line, shifting to or from its neighbors.
// Depends on ilb_pkg for the command struct and widths.
`timescale 1ns / 1ps

module ilb_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk,
  input  ilb_pkg::cell_cmd_t           cmd,
  input  logic [ilb_pkg::CHAR_W-1:0]   left_data,
  input  logic [ilb_pkg::CHAR_W-1:0]   right_data,
  input  logic [ilb_pkg::LEN_W-1:0]    rd_idx,
  output logic [ilb_pkg::CHAR_W-1:0]   data_o,
  output logic [ilb_pkg::CHAR_W-1:0]   rd_o
);

  localparam logic [ilb_pkg::LEN_W-1:0] MY_IDX = ilb_pkg::LEN_W'(IDX);

  logic [ilb_pkg::CHAR_W-1:0] data_r;
  logic [ilb_pkg::CHAR_W-1:0] data_nxt;

  // next byte from the broadcast command
  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      ilb_pkg::CELL_SHR: begin
        if (MY_IDX == cmd.pos) begin
          data_nxt = cmd.ch;
        end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.last) begin
          data_nxt = left_data;
        end
      end
      ilb_pkg::CELL_SHL: begin
        if (MY_IDX >= cmd.pos && MY_IDX < cmd.last) begin
          data_nxt = right_data;
        end
      end
      ilb_pkg::CELL_WRITE: begin
        if (MY_IDX == cmd.pos) begin
          data_nxt = cmd.ch;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // byte storage, no reset: only written slots are ever read
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // contribution to the read bus, zero unless addressed
  assign rd_o   = (MY_IDX == rd_idx) ? data_r : '0;

endmodule

// ----- rtl/ilb_chain.sv -----
// ilb_chain: the row of cells wired neighbor to neighbor plus the read bus.
// Depends on ilb_pkg and ilb_cell.
`timescale 1ns / 1ps

module ilb_chain (
  input  logic                         clk,
  input  ilb_pkg::cell_cmd_t           cmd,
  input  logic [ilb_pkg::LEN_W-1:0]    rd_idx,
  output logic [ilb_pkg::CHAR_W-1:0]   rd_data
);

  localparam int unsigned N = ilb_pkg::CAPACITY;

  logic [ilb_pkg::CHAR_W-1:0] cell_data [N];
  logic [ilb_pkg::CHAR_W-1:0] cell_rd   [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ilb_pkg::CHAR_W-1:0] left_w;
    logic [ilb_pkg::CHAR_W-1:0] right_w;

    // ends of the row see zero; those inputs are never selected
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[i+1];
    end

    ilb_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_w),
      .right_data (right_w),
      .rd_idx     (rd_idx),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // at most one cell drives a nonzero byte: OR them together
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < N; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

// ----- rtl/indexed_line_buffer.sv -----
// Indexed line buffer: one text line of up to 64 bytes with positional edits.
// in_req (sink): a word carries req_type, position and char_in. out_rsp (source):
// a word carries char_out, line_length and error, one per request, in order.
// Each request is decoded and applied to a row of 64 byte cells in the cycle
// it is accepted: insert and delete shift every cell behind the position by
// one place in that same cycle; one request is taken per clock unless out_rsp stalls.
// The result is registered: it appears on out_rsp in the cycle after acceptance.
// The result register is the only buffering. in_req.ready is high while it is
// empty or being emptied in the same cycle; if the receiver holds out_rsp.ready
// low, the result waits and in_req.ready stays low until it is taken.
// Reset (rst_n low at a clock edge) empties the line and drops any pending
// result; byte contents are not cleared, since only bytes below the line
// length are ever read and each of those was written first.
// Error results change nothing and return char_out zero.
`timescale 1ns / 1ps

module indexed_line_buffer (
  input  logic       clk,
  input  logic       rst_n,
  ilb_req_if.sink    in_req,
  ilb_rsp_if.source  out_rsp
);

  localparam int unsigned LEN_W  = ilb_pkg::LEN_W;
  localparam int unsigned CHAR_W = ilb_pkg::CHAR_W;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(ilb_pkg::CAPACITY);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              rsp_valid_r;
  logic [CHAR_W-1:0] rsp_char_r;
  logic [LEN_W-1:0]  rsp_len_r;
  logic              rsp_err_r;

  logic              accept;
  logic              err;
  logic [CHAR_W-1:0] res;
  logic [LEN_W-1:0]  rd_idx;
  logic [CHAR_W-1:0] rd_data;
  ilb_pkg::cell_cmd_t cmd_raw;
  ilb_pkg::cell_cmd_t cmd;
  logic [LEN_W-1:0]  len_dec;

  assign in_req.ready = !rsp_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  // request decode against the current length
  always_comb begin
    err             = 1'b0;
    res             = '0;
    rd_idx          = len_r - LEN_W'(1);
    len_dec         = len_r;
    cmd_raw.mode    = ilb_pkg::CELL_HOLD;
    cmd_raw.pos     = in_req.position;
    cmd_raw.last    = len_r;
    cmd_raw.ch      = in_req.char_in;
    case (in_req.req_type)
      ilb_pkg::REQ_INSERT: begin
        err          = (len_r == CAP) || (in_req.position > len_r);
        cmd_raw.mode = ilb_pkg::CELL_SHR;
        len_dec      = len_r + LEN_W'(1);
      end
      ilb_pkg::REQ_DELETE: begin
        err          = in_req.position >= len_r;
        cmd_raw.mode = ilb_pkg::CELL_SHL;
        cmd_raw.last = len_r - LEN_W'(1);
        len_dec      = len_r - LEN_W'(1);
      end
      ilb_pkg::REQ_READ: begin
        err    = in_req.position >= len_r;
        rd_idx = in_req.position;
        res    = rd_data;
      end
      ilb_pkg::REQ_WRITE: begin
        err          = in_req.position >= len_r;
        cmd_raw.mode = ilb_pkg::CELL_WRITE;
      end
      ilb_pkg::REQ_INS_POP: begin
        err = in_req.position > len_r;
        if (in_req.position == len_r) begin
          // byte at the end falls straight off again
          res = in_req.char_in;
        end else begin
          res          = rd_data;
          cmd_raw.mode = ilb_pkg::CELL_SHR;
          cmd_raw.last = len_r - LEN_W'(1);
        end
      end
      ilb_pkg::REQ_POP_HEAD: begin
        err          = len_r == '0;
        rd_idx       = '0;
        res          = rd_data;
        cmd_raw.mode = ilb_pkg::CELL_SHL;
        cmd_raw.pos  = '0;
        cmd_raw.last = len_r - LEN_W'(1);
        len_dec      = len_r - LEN_W'(1);
      end
      ilb_pkg::REQ_CLEAR: begin
        len_dec = '0;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // chain moves only on an accepted, valid request
  always_comb begin
    cmd = cmd_raw;
    if (!accept || err) begin
      cmd.mode = ilb_pkg::CELL_HOLD;
    end
  end

  assign len_nxt = (accept && !err) ? len_dec : len_r;

  ilb_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // line length and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (accept) begin
        rsp_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_char_r <= err ? '0 : res;
      rsp_len_r  <= len_nxt;
      rsp_err_r  <= err;
    end
  end

  assign out_rsp.valid       = rsp_valid_r;
  assign out_rsp.char_out    = rsp_char_r;
  assign out_rsp.line_length = rsp_len_r;
  assign out_rsp.error       = rsp_err_r;

endmodule
